// ===== design/sctl_pkg.sv =====
// ============================================================================
// sctl_pkg - shared constants for the sprite cache tag lookup
// Field widths, the light mask, opcodes and parameter defaults.
// ============================================================================
package sctl_pkg;

    // Field widths of the request and response
    localparam int TEX_W   = 16;
    localparam int LIGHT_W = 32;
    localparam int TRANS_W = 8;
    localparam int CMAP_W  = 8;
    localparam int SLOT_W  = 8;

    // Low bits of each light channel are dropped before tagging
    localparam logic [LIGHT_W-1:0] LIGHT_MASK = 32'hf8f8_f8f8;

    // Request opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Parameter defaults
    localparam int ENTRIES_DEF     = 256;
    localparam int TEX_ID_BITS_DEF = 16;

endpackage

// ===== design/sctl_if.sv =====
// ============================================================================
// sctl_if - request and response channels of the sprite cache tag lookup
// Valid/ready handshake; a request moves when both are high at a clock edge.
// ============================================================================
interface sctl_req_if import sctl_pkg::*;;
    logic               valid;
    logic               ready;
    logic               op;
    logic [TEX_W-1:0]   tex_id;
    logic [LIGHT_W-1:0] light;
    logic [TRANS_W-1:0] trans_id;
    logic [CMAP_W-1:0]  colour_map;
    logic               modified;

    modport source (output valid, op, tex_id, light, trans_id, colour_map, modified,
                    input ready);
    modport sink   (input valid, op, tex_id, light, trans_id, colour_map, modified,
                    output ready);
endinterface

interface sctl_rsp_if import sctl_pkg::*;;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;

    modport source (output valid, hit, slot, evicted, input ready);
    modport sink   (input valid, hit, slot, evicted, output ready);
endinterface

// ===== design/sctl_tag_mem.sv =====
// ============================================================================
// sctl_tag_mem - tag store RAM
// One write port, one read port, read data registered.
// ============================================================================
module sctl_tag_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 65,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/sprite_cache_tag_lookup.sv =====
// ============================================================================
// sprite_cache_tag_lookup - fully associative sprite tag store
// Serial scan of a tag RAM per lookup; lowest free slot or round-robin victim
// on a miss; flush clears the RAM.
// ============================================================================
//
//  channel  | dir | contents
//  ---------+-----+-----------------------------------------------------------
//  i_req    | in  | op, tex_id, light, trans_id, colour_map, modified
//  o_rsp    | out | hit, slot, evicted
//
//  Lookup: a serial scan through the tag RAM read port, one entry per cycle;
//  a hit ends the scan early.
//  Flush: a clearing pass through the RAM, one RAM write per entry.
//  After reset the RAM is cleared the same way; i_req.ready stays low.
//  One request at a time; a finished response waits in the output register
//  while the next request is taken, and the block stalls at its end until the
//  output register is free.
//
module sprite_cache_tag_lookup import sctl_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int TEX_ID_BITS = TEX_ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sctl_req_if.sink    i_req,
    sctl_rsp_if.source  o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W = TEX_ID_BITS + LIGHT_W + TRANS_W + CMAP_W;
    localparam int WORD_W = KEY_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Controller states
    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr;
    logic              r_is_flush, n_is_flush;
    logic [KEY_W-1:0]  r_key, n_key;
    logic              r_mod, n_mod;
    logic [IDX_W-1:0]  r_rd_addr, n_rd_addr;
    logic              r_issue, n_issue;
    logic              r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic              r_hit, n_hit;
    logic              r_free_found, n_free_found;
    logic [IDX_W-1:0]  r_claim, n_claim;
    logic [IDX_W-1:0]  r_victim, n_victim;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit, n_out_hit;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_ev, n_out_ev;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;

    logic                   rd_valid;
    logic [TEX_ID_BITS-1:0] rd_tex;
    logic                   tex_eq;
    logic                   key_eq;
    logic                   kill;
    logic                   eff_valid;
    logic                   hit_now;
    logic                   req_acc;
    logic                   out_free;

    // Tag RAM: {valid, tex, light, trans, cmap}
    sctl_tag_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W),
        .AW    (IDX_W)
    ) u_tag_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake
    assign i_req.ready   = (r_state == S_IDLE);
    assign req_acc       = i_req.valid && i_req.ready;
    assign out_free      = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.hit     = r_out_hit;
    assign o_rsp.slot    = r_out_slot;
    assign o_rsp.evicted = r_out_ev;

    // Compare of the entry read back against the request key
    assign rd_valid  = rd_data[KEY_W];
    assign rd_tex    = rd_data[KEY_W-1 -: TEX_ID_BITS];
    assign tex_eq    = (rd_tex == r_key[KEY_W-1 -: TEX_ID_BITS]);
    assign key_eq    = (rd_data[KEY_W-1:0] == r_key);
    assign kill      = rd_valid && r_mod && tex_eq;     // modified texture drops out
    assign eff_valid = rd_valid && !kill;
    assign hit_now   = r_chk_vld && eff_valid && key_eq;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_is_flush   = r_is_flush;
        n_key        = r_key;
        n_mod        = r_mod;
        n_rd_addr    = r_rd_addr;
        n_issue      = r_issue;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_claim      = r_claim;
        n_victim     = r_victim;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_hit    = r_out_hit;
        n_out_slot   = r_out_slot;
        n_out_ev     = r_out_ev;
        wr_en        = 1'b0;
        wr_addr      = r_chk_idx;
        wr_data      = {1'b0, rd_data[KEY_W-1:0]};

        unique case (r_state)
            // Clearing pass after reset or for a flush request
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                if (r_clr_addr == LAST_IDX) begin
                    n_clr_addr = '0;
                    n_state    = r_is_flush ? S_FINISH : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + IDX_W'(1);
                end
            end

            S_IDLE: begin
                if (req_acc) begin
                    n_key = {TEX_ID_BITS'(i_req.tex_id), i_req.light & LIGHT_MASK,
                             i_req.trans_id, i_req.colour_map};
                    n_mod        = i_req.modified;
                    n_rd_addr    = '0;
                    n_issue      = 1'b1;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    if (i_req.op == OP_FLUSH) begin
                        n_is_flush = 1'b1;
                        n_state    = S_CLEAR;
                    end else begin
                        n_state    = S_SCAN;
                    end
                end
            end

            // Read one entry per cycle, check it in the cycle after
            S_SCAN: begin
                n_chk_vld = r_issue;
                n_chk_idx = r_rd_addr;
                if (r_issue) begin
                    if (r_rd_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + IDX_W'(1);
                    end
                end
                if (r_chk_vld) begin
                    if (kill) begin
                        wr_en = 1'b1;
                    end
                    if (hit_now) begin
                        n_hit     = 1'b1;
                        n_claim   = r_chk_idx;
                        n_issue   = 1'b0;
                        n_chk_vld = 1'b0;
                        n_state   = S_FINISH;
                    end else begin
                        if (!eff_valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_claim      = r_chk_idx;
                        end
                        if (r_chk_idx == LAST_IDX) begin
                            n_chk_vld = 1'b0;
                            n_state   = S_FINISH;
                        end
                    end
                end
            end

            // Claim a slot and post the response once the output is free
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_ev    = 1'b0;
                    n_state     = S_IDLE;
                    if (r_is_flush) begin
                        n_is_flush = 1'b0;
                        n_out_slot = '0;
                    end else if (r_hit) begin
                        n_out_hit  = 1'b1;
                        n_out_slot = SLOT_W'(r_claim);
                    end else if (r_free_found) begin
                        wr_en      = 1'b1;
                        wr_addr    = r_claim;
                        wr_data    = {1'b1, r_key};
                        n_out_slot = SLOT_W'(r_claim);
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = r_victim;
                        wr_data    = {1'b1, r_key};
                        n_out_slot = SLOT_W'(r_victim);
                        n_out_ev   = 1'b1;
                        n_victim   = (r_victim == LAST_IDX) ? '0 : r_victim + IDX_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_is_flush  <= 1'b0;
            r_issue     <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_victim    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_is_flush  <= n_is_flush;
            r_issue     <= n_issue;
            r_chk_vld   <= n_chk_vld;
            r_victim    <= n_victim;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_mod        <= n_mod;
        r_rd_addr    <= n_rd_addr;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_free_found <= n_free_found;
        r_claim      <= n_claim;
        r_out_hit    <= n_out_hit;
        r_out_slot   <= n_out_slot;
        r_out_ev     <= n_out_ev;
    end

    // Checks
    a_hit_not_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_ev))
        else $error("response reports both hit and eviction");

    a_victim_moves_on_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_victim != $past(r_victim))) |-> (r_out_valid && r_out_ev))
        else $error("victim pointer moved without an eviction");

    a_chk_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_chk_idx <= LAST_IDX))
        else $error("scan checked an entry beyond the store");

    a_wr_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr <= LAST_IDX))
        else $error("tag RAM write beyond the store");

    a_scan_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_is_flush)
        else $error("scan running for a flush request");

endmodule

// ===== test/sprite_cache_tag_lookup_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sprite_cache_tag_lookup_tb - self-checking bench for the sprite tag store
// Drives lookup and flush requests through the request channel. The bench
// mirrors the tag store (valid bits, keys, round-robin victim pointer) to
// compute every expected response, and compares responses in order. A short
// directed list covers the field extremes, light masking, texture invalidation
// and flush. Random traffic, mostly from a key pool larger than the store, then
// exercises hits, free slots, holes and wrapping eviction, randomly stalled in its first two thirds.
// ============================================================================
module sprite_cache_tag_lookup_tb import sctl_pkg::*;;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int STALL_LIMIT  = 4000;          // cycles with no request or response moving
    localparam int DRAIN_CYCLES = ENTRIES + 40;
    localparam int RANDOM_REQS  = 1630;
    localparam int POOL_SIZE    = 400;           // more keys than slots, so the store overflows
    localparam int TEX_SET      = 32;

    typedef struct packed {
        logic               op;
        logic [TEX_W-1:0]   tex_id;
        logic [LIGHT_W-1:0] light;
        logic [TRANS_W-1:0] trans_id;
        logic [CMAP_W-1:0]  colour_map;
        logic               modified;
    } t_sprite_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } t_sprite_rsp;

    typedef struct packed {
        logic [TEX_W-1:0]   tex;
        logic [LIGHT_W-1:0] light;
        logic [TRANS_W-1:0] trans;
        logic [CMAP_W-1:0]  cmap;
    } t_tag_key;

    logic i_clk;
    logic i_rst_n;

    sctl_req_if req_if();
    sctl_rsp_if rsp_if();

    sprite_cache_tag_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Mirror of the tag store
    logic        tag_valid [ENTRIES];
    t_tag_key    tag_store [ENTRIES];
    int          victim_ptr;

    t_sprite_req pending_reqs[$];
    t_sprite_rsp expected_rsps[$];
    t_sprite_req req_hold;
    logic        req_taken;
    int          total_reqs;
    int          issued_reqs;
    int          mismatch_count;
    int          quiet_cycles;

    t_tag_key         key_pool [POOL_SIZE];
    logic [TEX_W-1:0] tex_set  [TEX_SET];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic t_sprite_req make_req(input logic op, input logic [TEX_W-1:0] tex,
                                             input logic [LIGHT_W-1:0] light,
                                             input logic [TRANS_W-1:0] trans,
                                             input logic [CMAP_W-1:0] cmap,
                                             input logic modified);
        t_sprite_req r;
        r.op         = op;
        r.tex_id     = tex;
        r.light      = light;
        r.trans_id   = trans;
        r.colour_map = cmap;
        r.modified   = modified;
        return r;
    endfunction

    // Tag store behavior: flush, per-texture invalidate, scan, claim
    function automatic t_sprite_rsp predict_tag_lookup(input t_sprite_req r);
        t_tag_key    k;
        int          free_idx;
        int          claim;
        t_sprite_rsp res;
        res = '0;
        if (r.op == OP_FLUSH) begin
            for (int i = 0; i < ENTRIES; i++) tag_valid[i] = 1'b0;
            return res;
        end
        k.tex   = r.tex_id;
        k.light = r.light & LIGHT_MASK;
        k.trans = r.trans_id;
        k.cmap  = r.colour_map;
        if (r.modified) begin
            for (int i = 0; i < ENTRIES; i++)
                if (tag_valid[i] && tag_store[i].tex == k.tex) tag_valid[i] = 1'b0;
        end
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tag_valid[i]) begin
                if (tag_store[i] == k) begin
                    res.hit  = 1'b1;
                    res.slot = i[SLOT_W-1:0];
                    return res;
                end
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (free_idx >= 0) begin
            claim = free_idx;
        end else begin
            claim       = victim_ptr;
            victim_ptr  = (victim_ptr + 1) % ENTRIES;
            res.evicted = 1'b1;
        end
        tag_store[claim] = k;
        tag_valid[claim] = 1'b1;
        res.slot         = claim[SLOT_W-1:0];
        return res;
    endfunction

    // Request driver and response ready, both at the falling edge
    always @(negedge i_clk) begin : drive_req
        logic nxt_valid;
        int   send_idle;
        int   recv_idle;
        if (issued_reqs < total_reqs / 3) begin
            send_idle = 33;
            recv_idle = 57;
        end else if (issued_reqs < 2 * total_reqs / 3) begin
            send_idle = 57;
            recv_idle = 33;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        nxt_valid = req_if.valid;
        if (i_rst_n && (!req_if.valid || req_taken)) begin
            nxt_valid = 1'b0;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                req_hold  = pending_reqs.pop_front();
                nxt_valid = 1'b1;
                issued_reqs++;
            end
        end
        req_if.valid      <= nxt_valid;
        req_if.op         <= req_hold.op;
        req_if.tex_id     <= req_hold.tex_id;
        req_if.light      <= req_hold.light;
        req_if.trans_id   <= req_hold.trans_id;
        req_if.colour_map <= req_hold.colour_map;
        req_if.modified   <= req_hold.modified;
        rsp_if.ready      <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Monitor: predict on accepted requests, check accepted responses
    always @(posedge i_clk) begin : watch_channels
        t_sprite_rsp got;
        t_sprite_rsp want;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready)
            expected_rsps.push_back(predict_tag_lookup({req_if.op, req_if.tex_id, req_if.light,
                                                        req_if.trans_id, req_if.colour_map,
                                                        req_if.modified}));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.hit, rsp_if.slot, rsp_if.evicted};
            if (expected_rsps.size() == 0) begin
                report_mismatch($sformatf("response %p with none expected", got));
            end else begin
                want = expected_rsps.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
                if (got.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %b, expected %b",
                                              got.evicted, want.evicted));
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge i_clk) begin : watchdog
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : run_test
        int          pick;
        int          roll;
        t_sprite_req r;
        t_tag_key    k;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.op         = OP_LOOKUP;
        req_if.tex_id     = '0;
        req_if.light      = '0;
        req_if.trans_id   = '0;
        req_if.colour_map = '0;
        req_if.modified   = 1'b0;
        rsp_if.ready      = 1'b0;
        req_hold          = '0;
        req_taken         = 1'b0;
        issued_reqs       = 0;
        mismatch_count    = 0;
        quiet_cycles      = 0;
        victim_ptr        = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_store[i] = '0;
        end

        // Directed: extremes, light masking, single-field misses, invalidate, flush
        pending_reqs.push_back(make_req(OP_FLUSH, 16'hffff, 32'hffff_ffff, 8'hff, 8'hff, 1'b1));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0707_0707, 8'h00, 8'h00, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'hffff, 32'hffff_ffff, 8'hff, 8'hff, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'hffff, 32'hf8f8_f8f8, 8'hff, 8'hff, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'hffff, 32'h0707_0707, 8'hff, 8'hff, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 8'h01, 8'h00, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 8'h00, 8'h01, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0001, 32'h0000_0000, 8'h00, 8'h00, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h8000, 32'h8000_0000, 8'h80, 8'h80, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'hffff, 32'h0000_0000, 8'hff, 8'hff, 1'b1));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'hffff, 32'hffff_ffff, 8'hff, 8'hff, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1'b1));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 8'h01, 8'h00, 1'b0));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h1234, 32'h5a5a_a5a5, 8'h3c, 8'hc3, 1'b0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1'b0));

        // Key pool: few textures so invalidation hits several entries
        tex_set[0] = 16'h0000;
        tex_set[1] = 16'hffff;
        for (int i = 2; i < TEX_SET; i++) tex_set[i] = TEX_W'($urandom());
        for (int i = 0; i < POOL_SIZE; i++) begin
            k.tex   = tex_set[$urandom_range(TEX_SET - 1)];
            k.light = $urandom();
            k.trans = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom());
            k.cmap  = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom());
            key_pool[i] = k;
        end

        // Random: mostly pool keys with noisy low light bits, some fresh keys, rare flushes
        for (int n = 0; n < RANDOM_REQS; n++) begin
            roll = $urandom_range(999);
            if (roll < 3) begin
                r = make_req(OP_FLUSH, TEX_W'($urandom()), $urandom(), TRANS_W'($urandom()),
                             CMAP_W'($urandom()), 1'($urandom_range(1)));
            end else if (roll < 100) begin
                r = make_req(OP_LOOKUP, TEX_W'($urandom()), $urandom(), TRANS_W'($urandom()),
                             CMAP_W'($urandom()), $urandom_range(99) < 3);
            end else begin
                pick = $urandom_range(POOL_SIZE - 1);
                k    = key_pool[pick];
                r    = make_req(OP_LOOKUP, k.tex, k.light ^ ($urandom() & ~LIGHT_MASK),
                                k.trans, k.cmap, $urandom_range(99) < 3);
            end
            pending_reqs.push_back(r);
        end
        total_reqs = pending_reqs.size();

        // Hold reset, then release it
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all requests to go in, then for every response
        while (pending_reqs.size() > 0 || req_if.valid) @(posedge i_clk);
        while (expected_rsps.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_rsps.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/sctl_pkg.sv
design/sctl_if.sv
design/sctl_tag_mem.sv
design/sprite_cache_tag_lookup.sv
test/sprite_cache_tag_lookup_tb.sv
